FILE: rtl/izh_pkg.sv
// shared types, constants and helpers for the izhikevich neuron update block
package izh_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int NEURON_BITS  = 10;
   localparam int NEURON_DEPTH = 1024;

   // fixed point constants, signed q16.16 (C140 widened to signed q22.16)
   localparam logic signed [31:0] V_RESET     = 32'(-65 * (2 ** FRAC_BITS));
   localparam logic signed [31:0] U_RESET     = 32'(-13 * (2 ** FRAC_BITS));
   localparam logic signed [37:0] C140        = 38'(140 * (2 ** FRAC_BITS));
   localparam logic signed [31:0] SPIKE_LEVEL = 32'(30 * (2 ** FRAC_BITS));

   // |current| / 500 as multiply by ceil(2^40 / 500) and shift by 40
   localparam logic [31:0] CUR_RECIP = 32'd2199023256;
   localparam int          CUR_SHIFT = 40;

   // floor(t / 25) for 40 bit t: 2^20 = 25 * 41943 + 1, low part by reciprocal
   localparam logic [15:0] SQ_HI_MULT = 16'd41943;
   localparam logic [21:0] SQ_RECIP   = 22'd2684355;
   localparam int          SQ_SHIFT   = 26;

   // configuration defaults
   localparam logic [15:0]        RATE_RESET  = 16'd1311;
   localparam logic [15:0]        SENS_RESET  = 16'd13107;
   localparam logic signed [23:0] VRST_RESET  = -24'sd4259840;
   localparam logic signed [23:0] JUMP_RESET  = 24'sd524288;
   localparam logic signed [23:0] BIAS_RESET  = 24'sd0;
   localparam logic [10:0]        COUNT_RESET = 11'd1024;

   typedef enum logic [2:0] {
      CSR_RATE    = 3'd0,
      CSR_SENS    = 3'd1,
      CSR_VRESET  = 3'd2,
      CSR_JUMP    = 3'd3,
      CSR_BIAS    = 3'd4,
      CSR_COUNT   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] recovery;
      logic signed [31:0] voltage;
   } neuron_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
      logic signed [31:0] r;
      if (x > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/izh_ram.sv
// generic single write port ram with registered read
module izh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/izhikevich_neuron_update.sv
// izhikevich neuron update: eight stage euler step pipeline over a per-neuron state ram
//
//  channel  | direction | handshake           | payload
//  req      | in        | req_tvalid/tready   | tdata: neuron_index, synaptic_current
//  rsp      | out       | rsp_tvalid/tready   | tdata: neuron_id, spiked, new_voltage,
//           |           |                     |        spike_byte; tlast: byte_ready
//  csr      | in        | csr_valid/ready     | csr_index, csr_data
//
// one item per cycle while rsp back pressure holds no stage; an item whose
// neuron is still in one of the eight stages waits until that update is
// written back.
// after reset a clearing pass writes all 1024 state ram entries; req_tready stays low.
// every stage holds under rsp back pressure and bubbles close up, so nothing is lost.
module izhikevich_neuron_update
   import izh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [9:0] neuron_index, [41:10] synaptic_current
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [9:0] neuron_id, [10] spiked, [42:11] new_voltage,
                                    // [50:43] spike_byte
   output logic        rsp_tlast,   // byte_ready
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   // configuration
   logic [15:0]        rrate_ff;
   logic [15:0]        rsens_ff;
   logic signed [23:0] vreset_ff;
   logic signed [23:0] vjump_ff;
   logic signed [23:0] bias_ff;
   logic [10:0]        ncount_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rrate_ff  <= RATE_RESET;
         rsens_ff  <= SENS_RESET;
         vreset_ff <= VRST_RESET;
         vjump_ff  <= JUMP_RESET;
         bias_ff   <= BIAS_RESET;
         ncount_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RATE:   rrate_ff  <= csr_data[15:0];
            CSR_SENS:   rsens_ff  <= csr_data[15:0];
            CSR_VRESET: vreset_ff <= csr_data;
            CSR_JUMP:   vjump_ff  <= csr_data;
            CSR_BIAS:   bias_ff   <= csr_data;
            CSR_COUNT:  ncount_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // clearing pass
   logic                   clearing_ff;
   logic [NEURON_BITS-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (&clr_cnt_ff) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // pipeline control
   logic [8:1]             stg_vld_ff;
   logic [9:1]             stg_rdy;
   logic [NEURON_BITS-1:0] idx_ff [1:8];
   logic                   rsp_valid_ff;
   logic [55:0]            rsp_data_ff;
   logic                   rsp_last_ff;
   logic [7:0]             acc_ff;
   logic                   hazard;
   logic                   req_acc;
   logic [NEURON_BITS-1:0] req_idx;
   logic                   pipe_wr;

   assign req_idx = req_tdata[9:0];

   always_comb begin
      stg_rdy[9] = !rsp_valid_ff || rsp_tready;
      for (int k = 8; k >= 1; k--) begin
         stg_rdy[k] = !stg_vld_ff[k] || stg_rdy[k+1];
      end
      hazard = 1'b0;
      for (int k = 1; k <= 8; k++) begin
         if (stg_vld_ff[k] && idx_ff[k] == req_idx) begin
            hazard = 1'b1;
         end
      end
   end

   assign req_tready = !clearing_ff && stg_rdy[1] && !hazard;
   assign req_acc    = req_tvalid && req_tready;
   assign pipe_wr    = stg_vld_ff[8] && stg_rdy[9];

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
      end else begin
         if (stg_rdy[1]) begin
            stg_vld_ff[1] <= req_acc;
         end
         for (int k = 2; k <= 8; k++) begin
            if (stg_rdy[k]) begin
               stg_vld_ff[k] <= stg_vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         idx_ff[1] <= req_idx;
      end
      for (int k = 2; k <= 8; k++) begin
         if (stg_rdy[k]) begin
            idx_ff[k] <= idx_ff[k-1];
         end
      end
   end

   // state ram
   neuron_state_type       rd_state;
   neuron_state_type       wr_state;
   logic                   wr_en;
   logic [NEURON_BITS-1:0] wr_addr;
   logic [63:0]            rd_word;

   izh_ram #(
      .WIDTH (64),
      .DEPTH (NEURON_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_state),
      .rd_en   (req_acc),
      .rd_addr (req_idx),
      .rd_data (rd_word)
   );

   assign rd_state = rd_word;

   // stage 1: squares and current scaling
   logic signed [31:0] cur1_ff;
   logic [31:0]        vabs_in;
   logic [31:0]        mag_in;
   logic [63:0]        sqp_in;
   logic [63:0]        cp_in;

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         cur1_ff <= req_tdata[41:10];
      end
   end

   always_comb begin
      vabs_in = rd_state.voltage[31] ? (~rd_state.voltage + 32'd1) : rd_state.voltage;
      mag_in  = cur1_ff[31] ? (~cur1_ff + 32'd1) : cur1_ff;
      sqp_in  = vabs_in * vabs_in;
      cp_in   = mag_in * CUR_RECIP;
   end

   // stage 2: split v^2 / 2^16 for the divide by 25
   logic signed [31:0] v2_ff, u2_ff;
   logic [63:0]        sqp2_ff;
   logic [23:0]        iq2_ff;
   logic [39:0]        t_in;
   logic [35:0]        hq_in;
   logic [20:0]        sum_in;

   always_ff @(posedge clock) begin
      if (stg_rdy[2]) begin
         v2_ff   <= rd_state.voltage;
         u2_ff   <= rd_state.recovery;
         sqp2_ff <= sqp_in;
         iq2_ff  <= cp_in[CUR_SHIFT+23:CUR_SHIFT];
      end
   end

   always_comb begin
      // beyond 2^40 the voltage sum saturates anyway
      t_in   = (|sqp2_ff[63:56]) ? '1 : sqp2_ff[55:FRAC_BITS];
      hq_in  = t_in[39:20] * SQ_HI_MULT;
      sum_in = {1'b0, t_in[39:20]} + {1'b0, t_in[19:0]};
   end

   // stage 3: low part of the divide by 25
   logic signed [31:0] v3_ff, u3_ff;
   logic [23:0]        iq3_ff;
   logic [35:0]        hq3_ff;
   logic [20:0]        sum3_ff;
   logic [42:0]        qp_in;

   always_ff @(posedge clock) begin
      if (stg_rdy[3]) begin
         v3_ff   <= v2_ff;
         u3_ff   <= u2_ff;
         iq3_ff  <= iq2_ff;
         hq3_ff  <= hq_in;
         sum3_ff <= sum_in;
      end
   end

   assign qp_in = sum3_ff * SQ_RECIP;

   // stage 4: quadratic term and linear part of the voltage sum
   logic signed [31:0] v4_ff, u4_ff;
   logic [23:0]        iq4_ff;
   logic [35:0]        hq4_ff;
   logic [16:0]        qlo4_ff;
   logic [35:0]        sq_in;
   logic signed [37:0] part_in;
   logic signed [37:0] v_ext, u_ext, iq_ext, bias_ext;

   always_ff @(posedge clock) begin
      if (stg_rdy[4]) begin
         v4_ff   <= v3_ff;
         u4_ff   <= u3_ff;
         iq4_ff  <= iq3_ff;
         hq4_ff  <= hq3_ff;
         qlo4_ff <= qp_in[SQ_SHIFT+16:SQ_SHIFT];
      end
   end

   always_comb begin
      v_ext    = {{6{v4_ff[31]}}, v4_ff};
      u_ext    = {{6{u4_ff[31]}}, u4_ff};
      iq_ext   = {14'd0, iq4_ff};
      bias_ext = {{14{bias_ff[23]}}, bias_ff};
      sq_in    = hq4_ff + {19'd0, qlo4_ff};
      part_in  = (v_ext <<< 2) + (v_ext <<< 1) - u_ext + iq_ext + bias_ext + C140;
   end

   // stage 5: new voltage and spike test
   logic signed [31:0] u5_ff;
   logic [35:0]        sq5_ff;
   logic signed [37:0] part5_ff;
   logic signed [37:0] vsum_in;
   logic signed [31:0] vn_in;

   always_ff @(posedge clock) begin
      if (stg_rdy[5]) begin
         u5_ff    <= u4_ff;
         sq5_ff   <= sq_in;
         part5_ff <= part_in;
      end
   end

   always_comb begin
      vsum_in = $signed({2'b00, sq5_ff}) + part5_ff;
      vn_in   = sat32({{2{vsum_in[37]}}, vsum_in});
   end

   // stage 6: b * v'
   logic signed [31:0] u6_ff, vn6_ff;
   logic               spk6_ff;
   logic signed [48:0] bvp_in;
   logic signed [33:0] diff_in;
   logic signed [33:0] bvs_ext, u6_ext;

   always_ff @(posedge clock) begin
      if (stg_rdy[6]) begin
         u6_ff   <= u5_ff;
         vn6_ff  <= vn_in;
         spk6_ff <= (vn_in >= SPIKE_LEVEL);
      end
   end

   always_comb begin
      bvp_in  = $signed({1'b0, rsens_ff}) * vn6_ff;
      bvs_ext = {bvp_in[48], bvp_in[48:16]};
      u6_ext  = {{2{u6_ff[31]}}, u6_ff};
      diff_in = bvs_ext - u6_ext;
   end

   // stage 7: a * (b v' - u)
   logic signed [31:0] u7_ff, vn7_ff;
   logic               spk7_ff;
   logic signed [33:0] diff7_ff;
   logic signed [50:0] adp_in;
   logic signed [39:0] usum_in;
   logic signed [31:0] un_in;

   always_ff @(posedge clock) begin
      if (stg_rdy[7]) begin
         u7_ff    <= u6_ff;
         vn7_ff   <= vn6_ff;
         spk7_ff  <= spk6_ff;
         diff7_ff <= diff_in;
      end
   end

   always_comb begin
      adp_in  = $signed({1'b0, rrate_ff}) * diff7_ff;
      usum_in = {{8{u7_ff[31]}}, u7_ff} + {{5{adp_in[50]}}, adp_in[50:16]};
      un_in   = sat32(usum_in);
   end

   // stage 8: spike reset, write back, spike byte
   logic signed [31:0] vn8_ff, un8_ff;
   logic               spk8_ff;
   logic signed [31:0] unj_in;
   logic signed [31:0] un_fin;
   logic signed [31:0] vn_fin;
   logic [2:0]         bit_sel;
   logic               last_in;
   logic [7:0]         acc_upd;
   logic [7:0]         byte_in;
   logic [7:0]         acc_in;
   logic [55:0]        rsp_data_in;

   always_ff @(posedge clock) begin
      if (stg_rdy[8]) begin
         vn8_ff  <= vn7_ff;
         spk8_ff <= spk7_ff;
         un8_ff  <= un_in;
      end
   end

   always_comb begin
      unj_in  = sat32({{8{un8_ff[31]}}, un8_ff} + {{16{vjump_ff[23]}}, vjump_ff});
      un_fin  = spk8_ff ? unj_in : un8_ff;
      vn_fin  = spk8_ff ? {{8{vreset_ff[23]}}, vreset_ff} : vn8_ff;
      bit_sel = idx_ff[8][2:0];
      last_in = (&bit_sel) || ({1'b0, idx_ff[8]} == (ncount_ff - 11'd1));
      acc_upd = spk8_ff ? (acc_ff | (8'd1 << bit_sel)) : (acc_ff & ~(8'd1 << bit_sel));
      byte_in = last_in ? acc_upd : 8'd0;
      acc_in  = last_in ? 8'd0 : acc_upd;
      rsp_data_in = {5'd0, byte_in, vn_fin, spk8_ff, idx_ff[8]};

      wr_en    = clearing_ff || pipe_wr;
      wr_addr  = clearing_ff ? clr_cnt_ff : idx_ff[8];
      wr_state = clearing_ff ? neuron_state_type'{recovery: U_RESET, voltage: V_RESET}
                             : neuron_state_type'{recovery: un_fin, voltage: vn_fin};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
      end else begin
         if (stg_rdy[9]) begin
            rsp_valid_ff <= stg_vld_ff[8];
         end
         if (pipe_wr) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[9]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_no_wb_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !pipe_wr)
      else $error("write back during clearing pass");

   a_no_adjacent_same: assert property (@(posedge clock) disable iff (reset)
      (stg_vld_ff[1] && stg_vld_ff[2]) |-> (idx_ff[1] != idx_ff[2]))
      else $error("same neuron twice in flight");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (pipe_wr && last_in) |=> (acc_ff == 8'd0))
      else $error("spike byte not cleared after release");

   a_spike_resets_v: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[10]) |->
         (rsp_data_ff[42:11] == {{8{vreset_ff[23]}}, vreset_ff}))
      else $error("spiking item without reset voltage");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_data_ff[50:43] == 8'd0))
      else $error("spike byte shown before group complete");

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the izhikevich neuron update block
module tb;
   import izh_pkg::*;

   localparam longint ONE_Q         = longint'(1) << FRAC_BITS;
   localparam longint CURRENT_SCALE = 32768000;
   localparam int     GAIN_BITS     = 16;      // a and b are q0.16
   localparam int     CYCLE_LIMIT   = 200000;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     PROBES        = 16;

   typedef struct {
      logic [9:0]  id;
      logic        spiked;
      logic [31:0] voltage;
      logic [7:0]  spike_byte;
      logic        ready;
   } neuron_update_type;

   // mirror of the per-neuron state and the expected update stream
   class neuron_scoreboard;
      longint            volt [NEURON_DEPTH];
      longint            recov [NEURON_DEPTH];
      logic [7:0]        spike_bits;
      longint            rate, sens, v_after_spike, u_jump, bias;
      logic [10:0]       count;
      neuron_update_type pending_updates [$];
      int                mismatches;

      function new();
         foreach (volt[i]) begin
            volt[i]  = -65 * ONE_Q;
            recov[i] = -13 * ONE_Q;
         end
         spike_bits    = '0;
         rate          = 1311;
         sens          = 13107;
         v_after_spike = -65 * ONE_Q;
         u_jump        = 8 * ONE_Q;
         bias          = 0;
         count         = 11'd1024;
         mismatches    = 0;
      endfunction

      function longint clip32(longint x);
         if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
         end
         if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
         end
         return x;
      endfunction

      function void set_register(csr_index_type k, logic [23:0] d);
         case (k)
            CSR_RATE:   rate = longint'(d[15:0]);
            CSR_SENS:   sens = longint'(d[15:0]);
            CSR_VRESET: v_after_spike = longint'($signed(d));
            CSR_JUMP:   u_jump = longint'($signed(d));
            CSR_BIAS:   bias = longint'($signed(d));
            CSR_COUNT:  count = d[10:0];
            default: ;
         endcase
      endfunction

      // one euler step for the accepted item, result queued
      function void step_neuron(logic [9:0] idx, logic [31:0] raw);
         longint            mag, iq, v, u, sq, vn, un;
         logic              fire, done;
         logic [10:0]       last_id;
         neuron_update_type upd;
         mag = longint'($signed(raw));
         if (mag < 0) begin
            mag = -mag;
         end
         iq = (mag * ONE_Q) / CURRENT_SCALE;
         v  = volt[idx];
         u  = recov[idx];
         sq = (v * v) / (25 * ONE_Q);
         vn = clip32(v + sq + 5 * v + 140 * ONE_Q - u + iq + bias);
         un = clip32(u + ((rate * (((sens * vn) >>> GAIN_BITS) - u)) >>> GAIN_BITS));
         fire = (vn >= 30 * ONE_Q);
         if (fire) begin
            un = clip32(un + u_jump);
            vn = v_after_spike;
            spike_bits[idx[2:0]] = 1'b1;
         end else begin
            spike_bits[idx[2:0]] = 1'b0;
         end
         volt[idx]  = vn;
         recov[idx] = un;
         // count of zero wraps to an id no neuron has
         last_id = count - 11'd1;
         done = (idx[2:0] == 3'd7) || ({1'b0, idx} == last_id);
         upd.id         = idx;
         upd.spiked     = fire;
         upd.voltage    = vn[31:0];
         upd.spike_byte = done ? spike_bits : 8'h00;
         upd.ready      = done;
         pending_updates.push_back(upd);
         if (done) begin
            spike_bits = '0;
         end
      endfunction

      task flag_mismatch(string what, int neuron, logic [31:0] got, logic [31:0] want);
         if (mismatches < 100) begin
            $display("mismatch %s on neuron %0d: got 0x%0h, expected 0x%0h",
                     what, neuron, got, want);
         end
         mismatches++;
      endtask

      task check_update(logic [55:0] data, logic last);
         neuron_update_type want;
         if (pending_updates.size() == 0) begin
            flag_mismatch("result with no item", data[9:0], data[42:11], 0);
            return;
         end
         want = pending_updates.pop_front();
         if (data[9:0] != want.id)
            flag_mismatch("neuron_id", want.id, data[9:0], want.id);
         if (data[10] != want.spiked)
            flag_mismatch("spiked", want.id, data[10], want.spiked);
         if (data[42:11] != want.voltage)
            flag_mismatch("new_voltage", want.id, data[42:11], want.voltage);
         if (data[50:43] != want.spike_byte)
            flag_mismatch("spike_byte", want.id, data[50:43], want.spike_byte);
         if (last != want.ready)
            flag_mismatch("byte_ready", want.id, last, want.ready);
         if (data[55:51] != '0)
            flag_mismatch("tdata padding", want.id, data[55:51], 0);
      endtask
   endclass

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [47:0]   req_tdata  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [55:0]   rsp_tdata;
   logic          rsp_tlast;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index  = CSR_RATE;
   logic [23:0]   csr_data   = '0;

   bit            steady     = 1'b0;
   bit            hold_asked = 1'b0;
   logic [23:0]   setting [6];
   csr_index_type reg_order [6] = '{CSR_RATE, CSR_SENS, CSR_VRESET, CSR_JUMP,
                                    CSR_BIAS, CSR_COUNT};

   logic [9:0]  probe_idx [PROBES] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6,
                                       10'd7, 10'd1, 10'd1, 10'd1, 10'h2aa, 10'h155,
                                       10'd1023, 10'd1022, 10'd1023};
   logic [31:0] probe_cur [PROBES] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                       32'hffff_ffff, 32'h0000_0001, 32'd500,
                                       32'hffff_fe0c, 32'h7fff_ffff, 32'h7fff_ffff,
                                       32'h7fff_ffff, 32'h8000_0000, 32'haaaa_aaaa,
                                       32'h5555_5555, 32'h7fff_ffff, 32'h0000_0000,
                                       32'h8000_0000};

   neuron_scoreboard scoreboard = new();

   izhikevich_neuron_update dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < 8);
   endfunction

   function automatic logic [31:0] pick_current();
      logic [31:0] mag;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 3))
            0: mag = 32'h8000_0000;
            1: mag = 32'h7fff_ffff;
            2: mag = '0;
            default: mag = '1;
         endcase
         return mag;
      end
      if (roll < 35) begin
         return $urandom();
      end
      if (roll < 85) begin
         mag = $urandom_range(0, 655360000);   // up to about 20 units of current
      end else begin
         mag = $urandom_range(0, 2000);
      end
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   task automatic send_item(input logic [9:0] idx, input logic [31:0] cur);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, cur, idx};
      do @(posedge clock); while (!req_tready);
      scoreboard.step_neuron(idx, cur);
      @(negedge clock);
   endtask

   // stop offering items and wait for every queued update to come back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (scoreboard.pending_updates.size() != 0);
   endtask

   task automatic load_parameters();
      foreach (reg_order[i]) begin
         csr_valid <= 1'b1;
         csr_index <= reg_order[i];
         csr_data  <= setting[reg_order[i]];
         do @(posedge clock); while (!csr_ready);
         scoreboard.set_register(reg_order[i], setting[reg_order[i]]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic draw_parameters(input int unsigned style);
      setting[CSR_RATE]   = 24'($urandom_range(0, 65535));
      setting[CSR_SENS]   = 24'($urandom_range(0, 65535));
      setting[CSR_VRESET] = 24'($urandom_range(0, 24'hff_ffff));
      setting[CSR_JUMP]   = 24'($urandom_range(0, 24'hff_ffff));
      if ($urandom_range(0, 1)) begin
         setting[CSR_BIAS] = 24'($urandom_range(0, 1310720)) - 24'd655360;
      end else begin
         setting[CSR_BIAS] = 24'($urandom_range(0, 24'hff_ffff));
      end
      case ($urandom_range(0, 3))
         0: setting[CSR_COUNT] = 24'd1024;
         1: setting[CSR_COUNT] = 24'($urandom_range(1, 1024));
         default: setting[CSR_COUNT] = 24'($urandom_range(1, 40));
      endcase
      case (style)
         0: begin
            setting[CSR_RATE]   = 24'd0;
            setting[CSR_SENS]   = 24'd0;
            setting[CSR_VRESET] = 24'h80_0000;
            setting[CSR_JUMP]   = 24'h80_0000;
            setting[CSR_BIAS]   = 24'h80_0000;
            setting[CSR_COUNT]  = 24'd1;
         end
         1: begin
            setting[CSR_RATE]   = 24'd65535;
            setting[CSR_SENS]   = 24'd65535;
            setting[CSR_VRESET] = 24'h7f_ffff;
            setting[CSR_JUMP]   = 24'h7f_ffff;
            setting[CSR_BIAS]   = 24'h7f_ffff;
            setting[CSR_COUNT]  = 24'd1024;
         end
         2: setting[CSR_COUNT] = 24'd2047;
         default: ;
      endcase
   endtask

   // mostly ascending runs over the neurons in use, some stray indexes
   task automatic drive_neurons(input int unsigned n, input int unsigned first,
                                input int unsigned span);
      int unsigned ptr;
      logic [9:0]  idx;
      ptr = (span > 64) ? span - 40 : 0;
      repeat (n) begin
         if ($urandom_range(0, 99) < 80) begin
            idx = 10'(first + ptr);
            ptr = (ptr + 1) % span;
         end else begin
            idx = 10'($urandom_range(0, 1023));
         end
         send_item(idx, pick_current());
      end
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_asked) begin
            hold_left  = HOLD_CYCLES;
            hold_asked = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !take_break();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         scoreboard.check_update(rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned p;
      int unsigned span;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // field extremes and a repeated neuron at the reset settings
      foreach (probe_idx[i]) begin
         send_item(probe_idx[i], probe_cur[i]);
      end
      settle();

      // five neurons in use: last byte released early with high bits clear
      setting[CSR_RATE]   = 24'd65535;
      setting[CSR_SENS]   = 24'd0;
      setting[CSR_VRESET] = 24'h80_0000;
      setting[CSR_JUMP]   = 24'h7f_ffff;
      setting[CSR_BIAS]   = 24'h7f_ffff;
      setting[CSR_COUNT]  = 24'd5;
      load_parameters();
      for (p = 0; p < 10; p++) begin
         send_item(10'(p % 5), '0);
      end
      settle();

      // one neuron, with some stray indexes, spiking every step with a large negative jump
      // drives u and v into saturation; the neuron count closes no byte
      setting[CSR_RATE]   = 24'd0;
      setting[CSR_SENS]   = 24'($urandom_range(0, 65535));
      setting[CSR_VRESET] = '0;
      setting[CSR_JUMP]   = 24'h80_0000;
      setting[CSR_BIAS]   = 24'h7f_ffff;
      setting[CSR_COUNT]  = 24'd0;
      load_parameters();
      drive_neurons(380, 1000, 1);

      for (p = 0; p < 9; p++) begin
         settle();
         draw_parameters(p);
         load_parameters();
         steady = (p == 4);
         if (p == 3) begin
            hold_asked = 1'b1;
         end
         span = (setting[CSR_COUNT] >= 1 && setting[CSR_COUNT] <= 1024) ?
                setting[CSR_COUNT] : 1024;
         drive_neurons(40, 0, span);
         if (p == 6) begin
            settle();
         end
         drive_neurons(40, 0, span);
      end
      steady = 1'b0;
      settle();
      repeat (20) @(negedge clock);
      if (scoreboard.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/izh_pkg.sv
rtl/izh_ram.sv
rtl/izhikevich_neuron_update.sv
tb/sv/tb.sv
